// ===== rtl/intermediate_correlation_solver_top_defines.svh =====
// assertion macros shared by the intermediate correlation solver rtl
`ifndef INTERMEDIATE_CORRELATION_SOLVER_TOP_DEFINES_SVH
`define INTERMEDIATE_CORRELATION_SOLVER_TOP_DEFINES_SVH

// property checked on every clock edge outside reset
`define ICS_CHECK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked in the cycle after a trigger condition
`define ICS_CHECK_NEXT(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/icor_pkg.sv =====
// types, constants and micro-op table of the intermediate correlation solver
package icor_pkg;

   localparam int VAL_W         = 64;
   localparam int PROD_W        = 2 * VAL_W;
   localparam int LIMB_W        = VAL_W / 2;
   localparam int CORR_W        = 32;
   localparam int BOUND_W       = 30;
   localparam int STATUS_W      = 2;
   localparam int RSP_W         = 40;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int UOP_W         = 5;
   localparam int ITER_LIMIT_DEF = 64;
   localparam int FRAC_BITS_DEF  = 30;

   localparam logic signed [VAL_W-1:0] SAT_LIM = 64'sh1000_0000_0000_0000;

   localparam logic signed [CORR_W-1:0] COEF_B_RST      = 32'sh4000_0000;
   localparam logic signed [CORR_W-1:0] COEF_C_RST      = '0;
   localparam logic signed [CORR_W-1:0] COEF_D_RST      = '0;
   localparam logic [BOUND_W-1:0]       ERROR_BOUND_RST = 30'd3395;

   localparam logic [UOP_W-1:0] UOP_LOOP = 5'd15;
   localparam logic [UOP_W-1:0] UOP_LAST = 5'd21;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_B      = 2'd0,
      CSR_COEF_C      = 2'd1,
      CSR_COEF_D      = 2'd2,
      CSR_ERROR_BOUND = 2'd3
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_CONVERGED = 2'd0,
      STAT_ITER_CAP  = 2'd1,
      STAT_SAT_LOW   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_EXEC,
      CS_MUL_WAIT,
      CS_DIFF,
      CS_TEST,
      CS_STEP,
      CS_FLOOR,
      CS_OUT
   } core_state_type;

   typedef enum logic [1:0] {
      MS_IDLE,
      MS_PROD,
      MS_SCALE,
      MS_SIGN
   } mul_state_type;

   typedef enum logic {
      UOP_MUL,
      UOP_ADD
   } uop_kind_type;

   typedef enum logic [3:0] {
      OPD_B,
      OPD_C,
      OPD_D,
      OPD_BB,
      OPD_BD,
      OPD_DD,
      OPD_CC,
      OPD_K1,
      OPD_K2,
      OPD_K3,
      OPD_T,
      OPD_RHO,
      OPD_R2,
      OPD_R3
   } opnd_type;

   typedef struct packed {
      uop_kind_type kind;
      opnd_type     src_a;
      opnd_type     src_b;
      opnd_type     dst;
   } uop_type;

   typedef struct packed {
      logic signed [CORR_W-1:0] coef_b;
      logic signed [CORR_W-1:0] coef_c;
      logic signed [CORR_W-1:0] coef_d;
      logic [BOUND_W-1:0]       error_bound;
   } cfg_type;

   typedef struct packed {
      logic                    start;
      logic signed [VAL_W-1:0] op_a;
      logic signed [VAL_W-1:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [VAL_W-1:0] result;
   } mul_rsp_type;

   // coefficient setup, then the polynomial evaluation loop
   function automatic uop_type uop_decode(input logic [UOP_W-1:0] idx);
      uop_type u;
      unique case (idx)
         5'd0:    u = '{UOP_MUL, OPD_B,   OPD_B,   OPD_BB};
         5'd1:    u = '{UOP_MUL, OPD_B,   OPD_D,   OPD_BD};
         5'd2:    u = '{UOP_MUL, OPD_D,   OPD_D,   OPD_DD};
         5'd3:    u = '{UOP_MUL, OPD_C,   OPD_C,   OPD_CC};
         5'd4:    u = '{UOP_ADD, OPD_BD,  OPD_BD,  OPD_T};
         5'd5:    u = '{UOP_ADD, OPD_T,   OPD_BD,  OPD_T};
         5'd6:    u = '{UOP_ADD, OPD_T,   OPD_T,   OPD_T};
         5'd7:    u = '{UOP_ADD, OPD_BB,  OPD_T,   OPD_K1};
         5'd8:    u = '{UOP_ADD, OPD_DD,  OPD_DD,  OPD_T};
         5'd9:    u = '{UOP_ADD, OPD_T,   OPD_DD,  OPD_DD};
         5'd10:   u = '{UOP_ADD, OPD_DD,  OPD_DD,  OPD_K3};
         5'd11:   u = '{UOP_ADD, OPD_DD,  OPD_DD,  OPD_T};
         5'd12:   u = '{UOP_ADD, OPD_T,   OPD_DD,  OPD_T};
         5'd13:   u = '{UOP_ADD, OPD_K1,  OPD_T,   OPD_K1};
         5'd14:   u = '{UOP_ADD, OPD_CC,  OPD_CC,  OPD_K2};
         5'd15:   u = '{UOP_MUL, OPD_RHO, OPD_RHO, OPD_R2};
         5'd16:   u = '{UOP_MUL, OPD_R2,  OPD_RHO, OPD_R3};
         5'd17:   u = '{UOP_MUL, OPD_K1,  OPD_RHO, OPD_BB};
         5'd18:   u = '{UOP_MUL, OPD_K2,  OPD_R2,  OPD_BD};
         5'd19:   u = '{UOP_MUL, OPD_K3,  OPD_R3,  OPD_R3};
         5'd20:   u = '{UOP_ADD, OPD_BB,  OPD_BD,  OPD_T};
         5'd21:   u = '{UOP_ADD, OPD_T,   OPD_R3,  OPD_T};
         default: u = '{UOP_ADD, OPD_T,   OPD_T,   OPD_T};
      endcase
      return u;
   endfunction

endpackage

// ===== rtl/icor_mul.sv =====
// shared fixed point multiplier built from four 32x32 partial products
`include "intermediate_correlation_solver_top_defines.svh"

module icor_mul #(
   parameter int FRAC_BITS = icor_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  icor_pkg::mul_req_type mul_req,
   output icor_pkg::mul_rsp_type mul_rsp
);
   import icor_pkg::*;

   localparam logic [2:0] PP_LAST = 3'd4;
   localparam logic [VAL_W-1:0] LIM_U = VAL_W'(SAT_LIM);

   mul_state_type state_ff, state_in;
   logic [2:0]              cnt_ff, cnt_in;
   logic [1:0]              psel_ff, psel_in;
   logic [VAL_W-1:0]        mag_a_ff, mag_a_in;
   logic [VAL_W-1:0]        mag_b_ff, mag_b_in;
   logic                    neg_ff, neg_in;
   logic [VAL_W-1:0]        prod_ff, prod_in;
   logic [PROD_W-1:0]       acc_ff, acc_in;
   logic [VAL_W-1:0]        mag_ff, mag_in;
   logic signed [VAL_W-1:0] result_ff, result_in;
   logic                    done_ff, done_in;

   logic [LIMB_W-1:0] limb_a;
   logic [LIMB_W-1:0] limb_b;
   logic [VAL_W-1:0]  limb_prod;
   logic [PROD_W-1:0] pp_shift;
   logic [PROD_W-1:0] scaled;

   assign limb_a    = cnt_ff[1] ? mag_a_ff[VAL_W-1:LIMB_W] : mag_a_ff[LIMB_W-1:0];
   assign limb_b    = cnt_ff[0] ? mag_b_ff[VAL_W-1:LIMB_W] : mag_b_ff[LIMB_W-1:0];
   assign limb_prod = limb_a * limb_b;
   assign scaled    = acc_ff >> FRAC_BITS;

   always_comb begin
      unique case (psel_ff)
         2'd0:    pp_shift = {{VAL_W{1'b0}}, prod_ff};
         2'd3:    pp_shift = {prod_ff, {VAL_W{1'b0}}};
         default: pp_shift = {{LIMB_W{1'b0}}, prod_ff, {LIMB_W{1'b0}}};
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MS_IDLE: begin
            if (mul_req.start) state_in = MS_PROD;
         end
         MS_PROD: begin
            if (cnt_ff == PP_LAST) state_in = MS_SCALE;
         end
         MS_SCALE: state_in = MS_SIGN;
         MS_SIGN:  state_in = MS_IDLE;
         default:  state_in = MS_IDLE;
      endcase
   end

   always_comb begin
      cnt_in    = cnt_ff;
      psel_in   = psel_ff;
      mag_a_in  = mag_a_ff;
      mag_b_in  = mag_b_ff;
      neg_in    = neg_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      mag_in    = mag_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         MS_IDLE: begin
            if (mul_req.start) begin
               mag_a_in = mul_req.op_a[VAL_W-1] ? VAL_W'(-mul_req.op_a) : VAL_W'(mul_req.op_a);
               mag_b_in = mul_req.op_b[VAL_W-1] ? VAL_W'(-mul_req.op_b) : VAL_W'(mul_req.op_b);
               neg_in   = mul_req.op_a[VAL_W-1] ^ mul_req.op_b[VAL_W-1];
               acc_in   = '0;
               cnt_in   = '0;
            end
         end
         MS_PROD: begin
            if (cnt_ff != PP_LAST) begin
               prod_in = limb_prod;
               psel_in = cnt_ff[1:0];
            end
            if (cnt_ff != 3'd0) acc_in = acc_ff + pp_shift;
            cnt_in = cnt_ff + 3'd1;
         end
         MS_SCALE: begin
            if ((|scaled[PROD_W-1:VAL_W]) || (scaled[VAL_W-1:0] > LIM_U)) begin
               mag_in = LIM_U;
            end else begin
               mag_in = scaled[VAL_W-1:0];
            end
         end
         MS_SIGN: begin
            result_in = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);
            done_in   = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      mul_rsp.done   = done_ff;
      mul_rsp.result = result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      psel_ff   <= psel_in;
      mag_a_ff  <= mag_a_in;
      mag_b_ff  <= mag_b_in;
      neg_ff    <= neg_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      mag_ff    <= mag_in;
      result_ff <= result_in;
   end

   `ICS_CHECK(a_start_idle, mul_req.start |-> (state_ff == MS_IDLE), "multiply started while busy")
   `ICS_CHECK_NEXT(a_done_pulse, done_ff, !done_ff, "multiply done held past one cycle")
   `ICS_CHECK(a_result_range, done_ff |-> (result_ff <= SAT_LIM && result_ff >= -SAT_LIM), "product outside clamp range")

endmodule

// ===== rtl/icor_core.sv =====
// search sequencer with operand registers and saturating adder
`include "intermediate_correlation_solver_top_defines.svh"

module icor_core #(
   parameter int ITER_LIMIT = icor_pkg::ITER_LIMIT_DEF,
   parameter int FRAC_BITS  = icor_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  icor_pkg::cfg_type              cfg,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [icor_pkg::CORR_W-1:0]    req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [icor_pkg::RSP_W-1:0]     rsp_tdata,
   output icor_pkg::mul_req_type          mul_req,
   input  icor_pkg::mul_rsp_type          mul_rsp
);
   import icor_pkg::*;

   localparam int ITER_W = $clog2(ITER_LIMIT + 1);
   localparam logic [ITER_W-1:0] ITER_MAX = ITER_W'(ITER_LIMIT);
   localparam logic signed [VAL_W-1:0] ONE_Q   = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [VAL_W-1:0] HALF_Q  = ONE_Q >>> 1;
   localparam logic signed [VAL_W-1:0] FLOOR_Q = -(ONE_Q <<< 1);

   function automatic logic signed [VAL_W-1:0] sat_add(
      input logic signed [VAL_W-1:0] a,
      input logic signed [VAL_W-1:0] b
   );
      logic signed [VAL_W-1:0] s;
      s = a + b;
      if (s > SAT_LIM) s = SAT_LIM;
      else if (s < -SAT_LIM) s = -SAT_LIM;
      return s;
   endfunction

   core_state_type state_ff, state_in;
   logic [UOP_W-1:0]        uop_ff, uop_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic signed [VAL_W-1:0] target_ff, target_in;
   logic signed [VAL_W-1:0] bb_ff, bb_in;
   logic signed [VAL_W-1:0] bd_ff, bd_in;
   logic signed [VAL_W-1:0] dd_ff, dd_in;
   logic signed [VAL_W-1:0] cc_ff, cc_in;
   logic signed [VAL_W-1:0] k1_ff, k1_in;
   logic signed [VAL_W-1:0] k2_ff, k2_in;
   logic signed [VAL_W-1:0] k3_ff, k3_in;
   logic signed [VAL_W-1:0] t_ff, t_in;
   logic signed [VAL_W-1:0] rho_ff, rho_in;
   logic signed [VAL_W-1:0] r2_ff, r2_in;
   logic signed [VAL_W-1:0] r3_ff, r3_in;
   logic signed [VAL_W-1:0] inc_ff, inc_in;
   logic signed [VAL_W-1:0] diff_ff, diff_in;
   logic                    down_ff, down_in;
   status_type              status_ff, status_in;

   uop_type                 uop;
   logic signed [VAL_W-1:0] opa;
   logic signed [VAL_W-1:0] opb;
   logic signed [VAL_W-1:0] wr_val;
   logic                    wr_en;
   logic signed [VAL_W-1:0] inc_half;
   logic [VAL_W-1:0]        err;
   logic                    in_bound;
   logic                    at_cap;

   assign uop      = uop_decode(uop_ff);
   assign inc_half = inc_ff >>> 1;
   assign err      = diff_ff[VAL_W-1] ? VAL_W'(-diff_ff) : VAL_W'(diff_ff);
   assign in_bound = err <= {{(VAL_W-BOUND_W){1'b0}}, cfg.error_bound};
   assign at_cap   = iter_ff >= ITER_MAX;

   always_comb begin
      unique case (uop.src_a)
         OPD_B:   opa = VAL_W'(cfg.coef_b);
         OPD_C:   opa = VAL_W'(cfg.coef_c);
         OPD_D:   opa = VAL_W'(cfg.coef_d);
         OPD_BB:  opa = bb_ff;
         OPD_BD:  opa = bd_ff;
         OPD_DD:  opa = dd_ff;
         OPD_CC:  opa = cc_ff;
         OPD_K1:  opa = k1_ff;
         OPD_K2:  opa = k2_ff;
         OPD_K3:  opa = k3_ff;
         OPD_RHO: opa = rho_ff;
         OPD_R2:  opa = r2_ff;
         OPD_R3:  opa = r3_ff;
         default: opa = t_ff;
      endcase
      unique case (uop.src_b)
         OPD_B:   opb = VAL_W'(cfg.coef_b);
         OPD_C:   opb = VAL_W'(cfg.coef_c);
         OPD_D:   opb = VAL_W'(cfg.coef_d);
         OPD_BB:  opb = bb_ff;
         OPD_BD:  opb = bd_ff;
         OPD_DD:  opb = dd_ff;
         OPD_CC:  opb = cc_ff;
         OPD_K1:  opb = k1_ff;
         OPD_K2:  opb = k2_ff;
         OPD_K3:  opb = k3_ff;
         OPD_RHO: opb = rho_ff;
         OPD_R2:  opb = r2_ff;
         OPD_R3:  opb = r3_ff;
         default: opb = t_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_tvalid) state_in = CS_EXEC;
         end
         CS_EXEC: begin
            if (uop.kind == UOP_MUL) state_in = CS_MUL_WAIT;
            else if (uop_ff == UOP_LAST) state_in = CS_DIFF;
         end
         CS_MUL_WAIT: begin
            if (mul_rsp.done) state_in = CS_EXEC;
         end
         CS_DIFF: state_in = CS_TEST;
         CS_TEST: begin
            priority if (in_bound) state_in = CS_OUT;
            else if (at_cap) state_in = CS_OUT;
            else state_in = CS_STEP;
         end
         CS_STEP: state_in = down_ff ? CS_FLOOR : CS_EXEC;
         CS_FLOOR: state_in = (rho_ff <= FLOOR_Q) ? CS_OUT : CS_EXEC;
         CS_OUT: begin
            if (rsp_tready) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   // handshake and multiplier request
   always_comb begin
      req_tready    = state_ff == CS_IDLE;
      rsp_tvalid    = state_ff == CS_OUT;
      rsp_tdata     = {{(RSP_W-CORR_W-STATUS_W){1'b0}}, status_ff, rho_ff[CORR_W-1:0]};
      mul_req.start = (state_ff == CS_EXEC) && (uop.kind == UOP_MUL);
      mul_req.op_a  = opa;
      mul_req.op_b  = opb;
   end

   // datapath
   always_comb begin
      uop_in    = uop_ff;
      iter_in   = iter_ff;
      target_in = target_ff;
      bb_in     = bb_ff;
      bd_in     = bd_ff;
      dd_in     = dd_ff;
      cc_in     = cc_ff;
      k1_in     = k1_ff;
      k2_in     = k2_ff;
      k3_in     = k3_ff;
      t_in      = t_ff;
      rho_in    = rho_ff;
      r2_in     = r2_ff;
      r3_in     = r3_ff;
      inc_in    = inc_ff;
      diff_in   = diff_ff;
      down_in   = down_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_val    = mul_rsp.result;

      unique case (state_ff)
         CS_IDLE: begin
            if (req_tvalid) begin
               target_in = VAL_W'($signed(req_tdata));
               uop_in    = '0;
               iter_in   = '0;
               rho_in    = ONE_Q;
               inc_in    = HALF_Q;
            end
         end
         CS_EXEC: begin
            if (uop.kind == UOP_ADD) begin
               wr_en  = 1'b1;
               wr_val = sat_add(opa, opb);
               if (uop_ff != UOP_LAST) uop_in = uop_ff + 1'b1;
            end
         end
         CS_MUL_WAIT: begin
            if (mul_rsp.done) begin
               wr_en  = 1'b1;
               uop_in = uop_ff + 1'b1;
            end
         end
         CS_DIFF: diff_in = t_ff - target_ff;
         CS_TEST: begin
            down_in = !diff_ff[VAL_W-1] && (diff_ff != '0);
            priority if (in_bound) status_in = STAT_CONVERGED;
            else if (at_cap) status_in = STAT_ITER_CAP;
            else iter_in = iter_ff + 1'b1;
         end
         CS_STEP: begin
            if (down_ff) begin
               rho_in = rho_ff - inc_ff;
            end else begin
               inc_in = inc_half;
               rho_in = rho_ff + inc_half;
               uop_in = UOP_LOOP;
            end
         end
         CS_FLOOR: begin
            if (rho_ff <= FLOOR_Q) begin
               rho_in    = FLOOR_Q;
               status_in = STAT_SAT_LOW;
            end else begin
               uop_in = UOP_LOOP;
            end
         end
         default: ;
      endcase

      if (wr_en) begin
         unique case (uop.dst)
            OPD_BB:  bb_in = wr_val;
            OPD_BD:  bd_in = wr_val;
            OPD_DD:  dd_in = wr_val;
            OPD_CC:  cc_in = wr_val;
            OPD_K1:  k1_in = wr_val;
            OPD_K2:  k2_in = wr_val;
            OPD_K3:  k3_in = wr_val;
            OPD_T:   t_in  = wr_val;
            OPD_R2:  r2_in = wr_val;
            OPD_R3:  r3_in = wr_val;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         uop_ff   <= '0;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         uop_ff   <= uop_in;
         iter_ff  <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      bb_ff     <= bb_in;
      bd_ff     <= bd_in;
      dd_ff     <= dd_in;
      cc_ff     <= cc_in;
      k1_ff     <= k1_in;
      k2_ff     <= k2_in;
      k3_ff     <= k3_in;
      t_ff      <= t_in;
      rho_ff    <= rho_in;
      r2_ff     <= r2_in;
      r3_ff     <= r3_in;
      inc_ff    <= inc_in;
      diff_ff   <= diff_in;
      down_ff   <= down_in;
      status_ff <= status_in;
   end

   `ICS_CHECK(a_mul_done_waits, mul_rsp.done |-> (state_ff == CS_MUL_WAIT), "stray product")
   `ICS_CHECK(a_iter_bound, iter_ff <= ITER_MAX, "iteration count past limit")
   `ICS_CHECK(a_rho_floor, (state_ff == CS_OUT) |-> (rho_ff >= FLOOR_Q), "rho below floor")
   `ICS_CHECK(a_cap_count, rsp_tvalid && status_ff == STAT_ITER_CAP |-> iter_ff == ITER_MAX, "early cap")

endmodule

// ===== rtl/intermediate_correlation_solver_top.sv =====
// Intermediate correlation solver: for each target correlation on the req stream it searches
// for rho so that k1*rho + k2*rho^2 + k3*rho^3 meets the target within error_bound, with
// k1, k2, k3 formed from the Fleishman coefficients b, c, d in the csr registers, and returns
// rho and a status (converged, iteration cap, rho saturated at -2) on the rsp stream. One
// transaction is in flight at a time; req_tready is low from acceptance until the result is
// taken. Every product goes through one shared multiplier that builds it from four 32x32
// partial products; a transaction runs the coefficient setup and then at most ITER_LIMIT + 1
// polynomial evaluations (the default limit is 64). Registers written through the csr port
// must stay unchanged while a transaction is in flight.
module intermediate_correlation_solver_top #(
   parameter int ITER_LIMIT = icor_pkg::ITER_LIMIT_DEF,
   parameter int FRAC_BITS  = icor_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [icor_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [icor_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [icor_pkg::CORR_W-1:0]         req_tdata,   // [31:0] target_corr
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [icor_pkg::RSP_W-1:0]          rsp_tdata    // [31:0] inter_corr, [33:32] status
);
   import icor_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_COEF_B:      cfg_in.coef_b      = csr_data;
            CSR_COEF_C:      cfg_in.coef_c      = csr_data;
            CSR_COEF_D:      cfg_in.coef_d      = csr_data;
            CSR_ERROR_BOUND: cfg_in.error_bound = csr_data[BOUND_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_b      <= COEF_B_RST;
         cfg_ff.coef_c      <= COEF_C_RST;
         cfg_ff.coef_d      <= COEF_D_RST;
         cfg_ff.error_bound <= ERROR_BOUND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   icor_core #(
      .ITER_LIMIT (ITER_LIMIT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mul_req    (mul_req),
      .mul_rsp    (mul_rsp)
   );

   icor_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

endmodule
